// ===== rtl/core/css_pkg.sv =====
package css_pkg;

   // surface and accumulator sizing
   localparam int SURFACE_SIZE = 4096;
   localparam int ACCUM_BITS   = 32;
   localparam int AREA_BITS    = (ACCUM_BITS + 8 > 64) ? 64 : ACCUM_BITS + 8;

   // coverage arithmetic: winding * 512 - area, then floor divide by 512
   localparam int FRAC_BITS = 9;
   localparam int WIDE_BITS = ((ACCUM_BITS + FRAC_BITS > AREA_BITS) ?
                               ACCUM_BITS + FRAC_BITS : AREA_BITS) + 1;
   localparam int QUOT_BITS = WIDE_BITS - FRAC_BITS;

   // field widths
   localparam int COL_BITS     = 12;
   localparam int ROW_BITS     = 12;
   localparam int LEN_BITS     = 13;
   localparam int COV_BITS     = 8;
   localparam int CVR_BITS     = 10;
   localparam int AREA_IN_BITS = 19;

   localparam logic [COV_BITS-1:0] COV_FULL = 8'd255;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // register file
   localparam int ADDR_BITS = 4;
   localparam logic [1:0] REG_CLIP_LEFT  = 2'd0;
   localparam logic [1:0] REG_CLIP_RIGHT = 2'd1;
   localparam logic [1:0] REG_FILL_RULE  = 2'd2;

   // queue entry kinds
   localparam logic [1:0] OP_EMIT  = 2'd0;
   localparam logic [1:0] OP_END   = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   localparam logic signed [ACCUM_BITS-1:0] ACC_MAX = {1'b0, {(ACCUM_BITS-1){1'b1}}};
   localparam logic signed [ACCUM_BITS-1:0] ACC_MIN = {1'b1, {(ACCUM_BITS-1){1'b0}}};
   localparam logic signed [AREA_BITS-1:0]  AREA_MAX = {1'b0, {(AREA_BITS-1){1'b1}}};
   localparam logic signed [AREA_BITS-1:0]  AREA_MIN = {1'b1, {(AREA_BITS-1){1'b0}}};

   typedef struct packed {
      logic [1:0]                    kind;
      logic                          item_end;
      logic [COL_BITS-1:0]           x;
      logic [ROW_BITS-1:0]           y;
      logic [LEN_BITS-1:0]           len;
      logic signed [ACCUM_BITS-1:0]  wind;
      logic signed [AREA_BITS-1:0]   area;
   } op_type;

   typedef struct packed {
      logic [COL_BITS-1:0] clip_left;
      logic [LEN_BITS-1:0] right_eff;
      logic                fill_rule;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // saturating add at accumulator width
   function automatic logic signed [ACCUM_BITS-1:0] sat_acc(
      input logic signed [ACCUM_BITS-1:0] a,
      input logic signed [ACCUM_BITS-1:0] b);
      logic signed [ACCUM_BITS:0] s;
      s = (ACCUM_BITS+1)'(a) + (ACCUM_BITS+1)'(b);
      if (s[ACCUM_BITS] != s[ACCUM_BITS-1]) begin
         return s[ACCUM_BITS] ? ACC_MIN : ACC_MAX;
      end
      return s[ACCUM_BITS-1:0];
   endfunction

   // saturating add at area width
   function automatic logic signed [AREA_BITS-1:0] sat_area(
      input logic signed [AREA_BITS-1:0] a,
      input logic signed [AREA_BITS-1:0] b);
      logic signed [AREA_BITS:0] s;
      s = (AREA_BITS+1)'(a) + (AREA_BITS+1)'(b);
      if (s[AREA_BITS] != s[AREA_BITS-1]) begin
         return s[AREA_BITS] ? AREA_MIN : AREA_MAX;
      end
      return s[AREA_BITS-1:0];
   endfunction

   // magnitude to 8-bit coverage: clamp (nonzero) or fold (even-odd)
   function automatic logic [COV_BITS-1:0] cov_fold(
      input logic [QUOT_BITS-1:0] mag,
      input logic                 rule);
      logic [8:0] m;
      m = mag[8:0];
      if (rule) begin
         if (m > 9'd256) begin
            return COV_BITS'(10'd512 - {1'b0, m});
         end else if (m == 9'd256) begin
            return COV_FULL;
         end
         return m[7:0];
      end
      if (mag >= QUOT_BITS'(256)) begin
         return COV_FULL;
      end
      return mag[7:0];
   endfunction

endpackage

// ===== rtl/core/css_ifs.sv =====
// cell word channel
interface css_cell_if;
   import css_pkg::*;

   logic                             valid;
   logic                             ready;
   logic [COL_BITS-1:0]              cell_x;
   logic [ROW_BITS-1:0]              cell_y;
   logic signed [CVR_BITS-1:0]       cell_cover;
   logic signed [AREA_IN_BITS-1:0]   cell_area;
   logic                             last_cell;

   modport source (output valid, cell_x, cell_y, cell_cover, cell_area, last_cell,
                   input ready);
   modport sink (input valid, cell_x, cell_y, cell_cover, cell_area, last_cell,
                 output ready);
endinterface

// span word channel
interface css_span_if;
   import css_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [COL_BITS-1:0]  span_x;
   logic [ROW_BITS-1:0]  span_y;
   logic [LEN_BITS-1:0]  span_length;
   logic [COV_BITS-1:0]  span_coverage;
   logic                 run_last;
   logic                 fill_done;

   modport source (output valid, span_x, span_y, span_length, span_coverage, run_last,
                   fill_done, input ready);
   modport sink (input valid, span_x, span_y, span_length, span_coverage, run_last,
                 fill_done, output ready);
endinterface

// ===== rtl/core/css_fifo.sv =====
module css_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  css_pkg::op_type         push_op,
   input  logic                    pop,
   output css_pkg::op_type         head,
   output css_pkg::fifo_stat_type  stat
);
   import css_pkg::*;

   op_type                mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  cnt_ff, cnt_in;

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.full  = (cnt_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);

endmodule

// ===== rtl/core/css_front.sv =====
module css_front (
   input  logic                    clock,
   input  logic                    reset,
   input  css_pkg::cfg_type        cfg,
   css_cell_if.sink                req_ch,
   output logic                    push,
   output css_pkg::op_type         push_op,
   input  css_pkg::fifo_stat_type  qstat
);
   import css_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_GAP   = 3'd1;
   localparam logic [2:0] ST_PIX   = 3'd2;
   localparam logic [2:0] ST_TAIL  = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

   logic [2:0]                     st_ff, st_in;
   logic                           fin_ff, fin_in;
   logic                           pv_ff, pv_in;
   logic [COL_BITS-1:0]            col_ff, col_in;
   logic [ROW_BITS-1:0]            row_ff, row_in;
   logic signed [ACCUM_BITS-1:0]   csum_ff, csum_in;
   logic signed [AREA_BITS-1:0]    asum_ff, asum_in;
   logic signed [ACCUM_BITS-1:0]   wind_ff, wind_in;
   logic [LEN_BITS-1:0]            next_ff, next_in;

   // stored cell that waits while the pending pixel is swept
   logic [COL_BITS-1:0]            cx_ff, cx_in;
   logic [ROW_BITS-1:0]            cy_ff, cy_in;
   logic signed [ACCUM_BITS-1:0]   ccov_ff, ccov_in;
   logic signed [AREA_BITS-1:0]    carea_ff, carea_in;
   logic                           clast_ff, clast_in;

   logic                           accept;
   logic                           same;
   logic                           gap_need;
   logic                           tail_need;
   logic                           row_chg;
   logic signed [ACCUM_BITS-1:0]   cov_ext;
   logic signed [AREA_BITS-1:0]    area_ext;
   logic signed [ACCUM_BITS-1:0]   wind_new;

   assign req_ch.ready = (st_ff == ST_IDLE) && !qstat.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign cov_ext      = ACCUM_BITS'(req_ch.cell_cover);
   assign area_ext     = AREA_BITS'(req_ch.cell_area);
   assign same         = pv_ff && (req_ch.cell_x == col_ff) && (req_ch.cell_y == row_ff);
   assign gap_need     = pv_ff && ({1'b0, col_ff} > next_ff) && (wind_ff != '0);
   assign tail_need    = (wind_ff != '0) && (next_ff < cfg.right_eff);
   assign row_chg      = (cy_ff != row_ff);
   assign wind_new     = sat_acc(wind_ff, csum_ff);

   // step sequencer: one queue entry at most per cycle
   always_comb begin
      st_in    = st_ff;
      fin_in   = fin_ff;
      pv_in    = pv_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      csum_in  = csum_ff;
      asum_in  = asum_ff;
      wind_in  = wind_ff;
      next_in  = next_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      ccov_in  = ccov_ff;
      carea_in = carea_ff;
      clast_in = clast_ff;
      push     = 1'b0;
      push_op  = '0;

      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               if (same) begin
                  // same pixel: accumulate
                  csum_in = sat_acc(csum_ff, cov_ext);
                  asum_in = sat_area(asum_ff, area_ext);
                  if (req_ch.last_cell) begin
                     fin_in = 1'b1;
                     st_in  = ST_GAP;
                  end
               end else if (pv_ff) begin
                  // new pixel: gap run now, pixel span next
                  cx_in    = req_ch.cell_x;
                  cy_in    = req_ch.cell_y;
                  ccov_in  = cov_ext;
                  carea_in = area_ext;
                  clast_in = req_ch.last_cell;
                  fin_in   = 1'b0;
                  st_in    = ST_PIX;
                  if (gap_need) begin
                     push         = 1'b1;
                     push_op.kind = OP_EMIT;
                     push_op.x    = next_ff[COL_BITS-1:0];
                     push_op.y    = row_ff;
                     push_op.len  = {1'b0, col_ff} - next_ff;
                     push_op.wind = wind_ff;
                  end
               end else begin
                  // nothing pending: load
                  pv_in   = 1'b1;
                  col_in  = req_ch.cell_x;
                  row_in  = req_ch.cell_y;
                  csum_in = cov_ext;
                  asum_in = area_ext;
                  if (req_ch.last_cell) begin
                     fin_in = 1'b1;
                     st_in  = ST_GAP;
                  end
               end
            end
         end

         ST_GAP: begin
            if (!qstat.full) begin
               st_in = ST_PIX;
               if (gap_need) begin
                  push         = 1'b1;
                  push_op.kind = OP_EMIT;
                  push_op.x    = next_ff[COL_BITS-1:0];
                  push_op.y    = row_ff;
                  push_op.len  = {1'b0, col_ff} - next_ff;
                  push_op.wind = wind_ff;
               end
            end
         end

         ST_PIX: begin
            if (!qstat.full) begin
               push             = 1'b1;
               push_op.kind     = OP_EMIT;
               push_op.item_end = !fin_ff && !row_chg && !clast_ff;
               push_op.x        = col_ff;
               push_op.y        = row_ff;
               push_op.len      = LEN_BITS'(1);
               push_op.wind     = wind_new;
               push_op.area     = asum_ff;
               wind_in          = wind_new;
               next_in          = {1'b0, col_ff} + 1'b1;
               if (fin_ff || row_chg) begin
                  st_in = ST_TAIL;
               end else begin
                  pv_in   = 1'b1;
                  col_in  = cx_ff;
                  row_in  = cy_ff;
                  csum_in = ccov_ff;
                  asum_in = carea_ff;
                  fin_in  = clast_ff;
                  st_in   = clast_ff ? ST_GAP : ST_IDLE;
               end
            end
         end

         ST_TAIL: begin
            if (!qstat.full) begin
               // tail run to the right clip, or a bare end marker
               if (tail_need) begin
                  push             = 1'b1;
                  push_op.kind     = OP_EMIT;
                  push_op.item_end = !fin_ff && !clast_ff;
                  push_op.x        = next_ff[COL_BITS-1:0];
                  push_op.y        = row_ff;
                  push_op.len      = cfg.right_eff - next_ff;
                  push_op.wind     = wind_ff;
               end else if (!fin_ff && !clast_ff) begin
                  push             = 1'b1;
                  push_op.kind     = OP_END;
                  push_op.item_end = 1'b1;
               end
               wind_in = '0;
               next_in = {1'b0, cfg.clip_left};
               if (fin_ff) begin
                  st_in = ST_FLUSH;
               end else begin
                  pv_in   = 1'b1;
                  col_in  = cx_ff;
                  row_in  = cy_ff;
                  csum_in = ccov_ff;
                  asum_in = carea_ff;
                  fin_in  = clast_ff;
                  st_in   = clast_ff ? ST_GAP : ST_IDLE;
               end
            end
         end

         ST_FLUSH: begin
            if (!qstat.full) begin
               push             = 1'b1;
               push_op.kind     = OP_FLUSH;
               push_op.item_end = 1'b1;
               pv_in            = 1'b0;
               col_in           = '0;
               row_in           = '0;
               csum_in          = '0;
               asum_in          = '0;
               wind_in          = '0;
               next_in          = {1'b0, cfg.clip_left};
               fin_in           = 1'b0;
               st_in            = ST_IDLE;
            end
         end

         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         fin_ff  <= 1'b0;
         pv_ff   <= 1'b0;
         col_ff  <= '0;
         row_ff  <= '0;
         csum_ff <= '0;
         asum_ff <= '0;
         wind_ff <= '0;
         next_ff <= '0;
      end else begin
         st_ff   <= st_in;
         fin_ff  <= fin_in;
         pv_ff   <= pv_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         csum_ff <= csum_in;
         asum_ff <= asum_in;
         wind_ff <= wind_in;
         next_ff <= next_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      ccov_ff  <= ccov_in;
      carea_ff <= carea_in;
      clast_ff <= clast_in;
   end

endmodule

// ===== rtl/core/css_back.sv =====
module css_back (
   input  logic                    clock,
   input  logic                    reset,
   input  css_pkg::cfg_type        cfg,
   output logic                    pop,
   input  css_pkg::op_type         head,
   input  css_pkg::fifo_stat_type  qstat,
   css_span_if.source              rsp_ch
);
   import css_pkg::*;

   typedef struct packed {
      logic [1:0]           kind;
      logic                 item_end;
      logic [COL_BITS-1:0]  x;
      logic [ROW_BITS-1:0]  y;
      logic [LEN_BITS-1:0]  len;
   } stage_type;

   typedef struct packed {
      logic [COL_BITS-1:0]  x;
      logic [ROW_BITS-1:0]  y;
      logic [LEN_BITS-1:0]  len;
      logic [COV_BITS-1:0]  cov;
      logic                 done;
   } span_type;

   localparam logic PH_MAIN = 1'b0;
   localparam logic PH_END  = 1'b1;

   // stage 1: scaled winding minus area, floor-divided
   logic                          s1v_ff, s1v_in;
   stage_type                     s1_ff, s1_in;
   logic signed [QUOT_BITS-1:0]   s1q_ff, s1q_in;
   logic signed [WIDE_BITS-1:0]   wide;

   // stage 2: coverage ready for merging
   logic                          cv_ff, cv_in;
   stage_type                     cur_ff, cur_in;
   logic [COV_BITS-1:0]           ccov_ff, ccov_in;
   logic [QUOT_BITS-1:0]          mag;

   // held span, staged output, result register
   logic                          hv_ff, hv_in;
   span_type                      held_ff, held_in;
   logic                          sv_ff, sv_in;
   span_type                      stg_ff, stg_in;
   logic                          phase_ff, phase_in;
   logic                          ov_ff, ov_in;
   span_type                      out_ff, out_in;
   logic                          orl_ff, orl_in;

   logic                          b_pop;
   logic                          cur_take;
   logic                          out_free;
   logic                          emit_new;
   logic                          merge;
   logic                          put_v;
   span_type                      put;
   span_type                      newspan;
   logic                          s_after_v;
   span_type                      s_after;
   logic                          out1;
   logic                          need_end;
   logic [LEN_BITS:0]             hend;

   // pipeline advance
   assign cur_take = s1v_ff && (!cv_ff || b_pop);
   assign pop      = !qstat.empty && (!s1v_ff || cur_take);

   always_comb begin
      wide     = (WIDE_BITS'(head.wind) <<< FRAC_BITS) - WIDE_BITS'(head.area);
      s1v_in   = s1v_ff;
      s1_in    = s1_ff;
      s1q_in   = s1q_ff;
      if (pop) begin
         s1v_in         = 1'b1;
         s1_in.kind     = head.kind;
         s1_in.item_end = head.item_end;
         s1_in.x        = head.x;
         s1_in.y        = head.y;
         s1_in.len      = head.len;
         s1q_in         = wide[WIDE_BITS-1:FRAC_BITS];
      end else if (cur_take) begin
         s1v_in = 1'b0;
      end
   end

   always_comb begin
      mag     = s1q_ff[QUOT_BITS-1] ? QUOT_BITS'(-s1q_ff) : QUOT_BITS'(s1q_ff);
      cv_in   = cv_ff;
      cur_in  = cur_ff;
      ccov_in = ccov_ff;
      if (cur_take) begin
         cv_in   = 1'b1;
         cur_in  = s1_ff;
         ccov_in = cov_fold(mag, cfg.fill_rule);
      end else if (b_pop) begin
         cv_in = 1'b0;
      end
   end

   // merge against the held span
   always_comb begin
      hend         = {1'b0, held_ff.x} + {1'b0, held_ff.len};
      emit_new     = cv_ff && (cur_ff.kind == OP_EMIT) && (ccov_ff != '0) &&
                     (cur_ff.len != '0);
      merge        = emit_new && hv_ff && (held_ff.y == cur_ff.y) &&
                     (held_ff.cov == ccov_ff) && (hend == (LEN_BITS+1)'(cur_ff.x));
      put_v        = hv_ff && ((emit_new && !merge) ||
                     (cv_ff && (cur_ff.kind == OP_FLUSH)));
      put          = held_ff;
      put.done     = (cur_ff.kind == OP_FLUSH);
      newspan.x    = cur_ff.x;
      newspan.y    = cur_ff.y;
      newspan.len  = cur_ff.len;
      newspan.cov  = ccov_ff;
      newspan.done = 1'b0;
      s_after_v    = put_v || sv_ff;
      s_after      = put_v ? put : stg_ff;
      out1         = put_v && sv_ff;
      need_end     = cur_ff.item_end && s_after_v;
   end

   // retire one queue entry; at most one word to the result register per cycle
   always_comb begin
      out_free = !ov_ff || rsp_ch.ready;
      hv_in    = hv_ff;
      held_in  = held_ff;
      sv_in    = sv_ff;
      stg_in   = stg_ff;
      phase_in = phase_ff;
      ov_in    = ov_ff;
      out_in   = out_ff;
      orl_in   = orl_ff;
      b_pop    = 1'b0;

      if (ov_ff && rsp_ch.ready) begin
         ov_in = 1'b0;
      end

      if (cv_ff) begin
         unique case (phase_ff)
            PH_END: begin
               if (out_free) begin
                  ov_in    = 1'b1;
                  out_in   = stg_ff;
                  orl_in   = 1'b1;
                  sv_in    = 1'b0;
                  phase_in = PH_MAIN;
                  b_pop    = 1'b1;
               end
            end
            PH_MAIN: begin
               if (out_free || !(out1 || need_end)) begin
                  if (merge) begin
                     held_in.len = held_ff.len + cur_ff.len;
                  end else if (emit_new) begin
                     hv_in   = 1'b1;
                     held_in = newspan;
                  end else if (cur_ff.kind == OP_FLUSH) begin
                     hv_in = 1'b0;
                  end

                  if (out1) begin
                     ov_in  = 1'b1;
                     out_in = stg_ff;
                     orl_in = 1'b0;
                     sv_in  = 1'b1;
                     stg_in = put;
                     if (need_end) begin
                        phase_in = PH_END;
                     end else begin
                        b_pop = 1'b1;
                     end
                  end else if (need_end) begin
                     ov_in  = 1'b1;
                     out_in = s_after;
                     orl_in = 1'b1;
                     sv_in  = 1'b0;
                     b_pop  = 1'b1;
                  end else begin
                     sv_in  = s_after_v;
                     stg_in = s_after;
                     b_pop  = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = PH_MAIN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1v_ff   <= 1'b0;
         cv_ff    <= 1'b0;
         hv_ff    <= 1'b0;
         sv_ff    <= 1'b0;
         phase_ff <= PH_MAIN;
         ov_ff    <= 1'b0;
      end else begin
         s1v_ff   <= s1v_in;
         cv_ff    <= cv_in;
         hv_ff    <= hv_in;
         sv_ff    <= sv_in;
         phase_ff <= phase_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff   <= s1_in;
      s1q_ff  <= s1q_in;
      cur_ff  <= cur_in;
      ccov_ff <= ccov_in;
      held_ff <= held_in;
      stg_ff  <= stg_in;
      out_ff  <= out_in;
      orl_ff  <= orl_in;
   end

   assign rsp_ch.valid         = ov_ff;
   assign rsp_ch.span_x        = out_ff.x;
   assign rsp_ch.span_y        = out_ff.y;
   assign rsp_ch.span_length   = out_ff.len;
   assign rsp_ch.span_coverage = out_ff.cov;
   assign rsp_ch.run_last      = orl_ff;
   assign rsp_ch.fill_done     = out_ff.done;

endmodule

// ===== rtl/core/coverage_span_sweep.sv =====
// Front: a cell that hits the pending pixel or starts a fill adds no queue entry; a new pixel
// in a row adds a gap run and a pixel span, a row change also the tail run. Back: one queue
// entry per cycle while the result register has room; an entry that both releases a span
// and ends its word also passes PH_END. Queue entries pass stage 1 and stage 2; spans are
// then held for merging and leave when a later span breaks the run or at last_cell.
// Reset (synchronous): clears all control state; clip_left 0, clip_right 4096, fill_rule 0.
module coverage_span_sweep (
   input  logic                            clock,
   input  logic                            reset,
   css_cell_if.sink                        req_ch,
   css_span_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [css_pkg::ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import css_pkg::*;

   logic [COL_BITS-1:0]  clip_left_ff, clip_left_in;
   logic [LEN_BITS-1:0]  clip_right_ff, clip_right_in;
   logic                 fill_rule_ff, fill_rule_in;

   logic                 csr_wr;
   logic [1:0]           csr_idx;
   cfg_type              cfg;
   logic                 q_push;
   op_type               q_push_op;
   logic                 q_pop;
   op_type               q_head;
   fifo_stat_type        q_stat;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      clip_left_in  = clip_left_ff;
      clip_right_in = clip_right_ff;
      fill_rule_in  = fill_rule_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_CLIP_LEFT:  clip_left_in  = csr_pwdata[COL_BITS-1:0];
            REG_CLIP_RIGHT: clip_right_in = csr_pwdata[LEN_BITS-1:0];
            REG_FILL_RULE:  fill_rule_in  = csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_CLIP_LEFT:  csr_prdata = 32'(clip_left_ff);
         REG_CLIP_RIGHT: csr_prdata = 32'(clip_right_ff);
         REG_FILL_RULE:  csr_prdata = 32'(fill_rule_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff  <= '0;
         clip_right_ff <= LEN_BITS'(4096);
         fill_rule_ff  <= 1'b0;
      end else begin
         clip_left_ff  <= clip_left_in;
         clip_right_ff <= clip_right_in;
         fill_rule_ff  <= fill_rule_in;
      end
   end

   // right clip limited to the surface
   assign cfg.clip_left = clip_left_ff;
   assign cfg.right_eff = (int'(clip_right_ff) > SURFACE_SIZE) ?
                          LEN_BITS'(SURFACE_SIZE) : clip_right_ff;
   assign cfg.fill_rule = fill_rule_ff;

   css_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_ch  (req_ch),
      .push    (q_push),
      .push_op (q_push_op),
      .qstat   (q_stat)
   );

   css_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_push_op),
      .pop     (q_pop),
      .head    (q_head),
      .stat    (q_stat)
   );

   css_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .pop    (q_pop),
      .head   (q_head),
      .qstat  (q_stat),
      .rsp_ch (rsp_ch)
   );

   // checks
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue written while full");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue read while empty");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.fill_done) |-> rsp_ch.run_last)
      else $error("fill_done span does not close its word");

endmodule
